[rtl/core/nearest_node_within_range_macros.svh]
// Assertion macros for the nearest node search RTL, used by nnwr_dpath.
// Each macro checks one implication on the rising clock edge and is
// switched off while the synchronous active-low reset is asserted.
`ifndef NEAREST_NODE_WITHIN_RANGE_MACROS_SVH
`define NEAREST_NODE_WITHIN_RANGE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: when ante holds, cons holds in the same cycle.
`define NNWR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nearest node search: assertion failed");

// Next-cycle implication: when ante holds, cons holds in the following cycle.
`define NNWR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nearest node search: assertion failed");

`else

`define NNWR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define NNWR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/nnwr_pkg.sv]
`default_nettype none

package nnwr_pkg;

    // Coordinate format: signed fixed point, 4 fractional bits.
    localparam int COORD_BITS = 20;
    localparam int DIF_W      = COORD_BITS + 1;
    localparam int SQ_W       = 2 * DIF_W;
    localparam int SUM_W      = SQ_W + 2;

    localparam int SLOT_W  = 8;
    localparam int IDENT_W = 16;
    localparam int MAP_W   = 16;
    localparam int RANGE_W = 16;
    localparam int RSQ_W   = 2 * RANGE_W;
    localparam int ROW_W   = 9;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_RANGE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT   = 1'b1;

    localparam logic [RANGE_W-1:0] MATCH_RANGE_RST = 16'd960;
    localparam logic [ROW_W-1:0]   ROW_COUNT_RST   = 9'd256;

    // Item modes.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic                         mode;
        logic [SLOT_W-1:0]            slot;
        logic                         slot_present;
        logic [IDENT_W-1:0]           node_ident;
        logic [MAP_W-1:0]             map_number;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [IDENT_W-1:0] best_node;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;
        logic ld_wr;
        logic q_start;
        logic scan_issue;
        logic out_load;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic scan_none;
        logic scan_last;
        logic pipe_empty;
        logic out_busy;
    } t_ctl_stat;

endpackage

`default_nettype wire

[rtl/core/nearest_node_within_range.sv]
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_in_item  (nnwr_pkg::t_in_item)
// out       output     o_out_valid / i_out_ready  o_out_item (nnwr_pkg::t_out_item)
// cfg       input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// A load item gives no result and leaves the block ready for the next item.
// A query item scans slots 1 to L-1, with L = min(row_count, TABLE_SLOTS), at
// one slot per cycle through the single read port of the slot table. It then
// waits in DRAIN until the distance pipeline is empty and in DONE until the
// output register is free, loads its result there and returns to IDLE; only
// then is the next item taken. When L is 0 or 1 nothing is scanned and the
// query goes from IDLE straight to DRAIN. After reset the table is swept once
// to clear the valid marks, and no item is accepted meanwhile. Configuration
// writes are taken always. A result held in the output register does not block
// loads; a following query waits at its end until the register is free.
`default_nettype none

module nearest_node_within_range #(
    parameter int TABLE_SLOTS = 256
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire nnwr_pkg::t_in_item                  i_in_item,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output nnwr_pkg::t_out_item                      o_out_item,
    input  wire logic                                i_cfg_we,
    input  wire logic [nnwr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [nnwr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // The controller sequences the clearing pass, loads, the scan and the
    // hand-over of the result; the datapath holds the table, the distance
    // pipeline (read, difference, square, sum, compare) and the result register.
    nnwr_pkg::t_ctl_cmd  w_cmd;
    nnwr_pkg::t_ctl_stat w_stat;

    nnwr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_mode  (i_in_item.mode),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    nnwr_dpath #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

[rtl/core/nnwr_ctrl.sv]
`default_nettype none

module nnwr_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_mode,
    output logic                    o_in_ready,
    output nnwr_pkg::t_ctl_cmd      o_cmd,
    input  wire nnwr_pkg::t_ctl_stat i_stat
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_mode == nnwr_pkg::MODE_QUERY) begin
                        o_cmd.q_start = 1'b1;
                        n_state = i_stat.scan_none ? S_DRAIN : S_SCAN;
                    end else begin
                        o_cmd.ld_wr = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_stat.pipe_empty) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[rtl/core/nnwr_dpath.sv]
`default_nettype none

`include "nearest_node_within_range_macros.svh"

module nnwr_dpath #(
    parameter int TABLE_SLOTS = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire nnwr_pkg::t_in_item    i_in_item,
    input  wire logic                  i_cfg_we,
    input  wire logic [nnwr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [nnwr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire nnwr_pkg::t_ctl_cmd    i_cmd,
    output nnwr_pkg::t_ctl_stat        o_stat,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output nnwr_pkg::t_out_item        o_out_item
);

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int LIM_W = $clog2(TABLE_SLOTS + 1);
    localparam int CW    = (LIM_W > nnwr_pkg::ROW_W) ? LIM_W : nnwr_pkg::ROW_W;
    localparam int CB    = nnwr_pkg::COORD_BITS;
    localparam int DW    = nnwr_pkg::DIF_W;
    localparam int SQW   = nnwr_pkg::SQ_W;
    localparam int SMW   = nnwr_pkg::SUM_W;

    typedef struct packed {
        logic                                 valid;
        logic [nnwr_pkg::MAP_W-1:0]           map;
        logic [nnwr_pkg::IDENT_W-1:0]         ident;
        logic signed [CB-1:0]                 x;
        logic signed [CB-1:0]                 y;
        logic signed [CB-1:0]                 z;
    } t_slot_rec;

    // Configuration registers.
    logic [nnwr_pkg::RANGE_W-1:0] r_match_range;
    logic [nnwr_pkg::ROW_W-1:0]   r_row_count;

    // Slot table.
    t_slot_rec r_mem [TABLE_SLOTS];
    logic                 w_we;
    logic [IDX_W-1:0]     w_waddr;
    t_slot_rec            w_wdata;

    // Scan control.
    logic [LIM_W-1:0] r_idx;
    logic [LIM_W-1:0] r_limit;
    logic [CW-1:0]    w_row_ext;
    logic [CW-1:0]    w_lim;

    // Query point.
    logic [nnwr_pkg::MAP_W-1:0] r_qmap;
    logic signed [CB-1:0]       r_qx;
    logic signed [CB-1:0]       r_qy;
    logic signed [CB-1:0]       r_qz;
    logic [nnwr_pkg::RSQ_W-1:0] w_rsq;

    // Distance pipeline.
    t_slot_rec                     r_rd;
    logic                          r_v1;
    logic                          r_v2;
    logic                          r_v3;
    logic                          r_v4;
    logic signed [DW-1:0]          w_dx;
    logic signed [DW-1:0]          w_dy;
    logic signed [DW-1:0]          w_dz;
    logic [DW-1:0]                 r_ax;
    logic [DW-1:0]                 r_ay;
    logic [DW-1:0]                 r_az;
    logic [nnwr_pkg::IDENT_W-1:0]  r_id2;
    logic [SQW-1:0]                r_sqx;
    logic [SQW-1:0]                r_sqy;
    logic [SQW-1:0]                r_sqz;
    logic [nnwr_pkg::IDENT_W-1:0]  r_id3;
    logic [SMW-1:0]                r_sum;
    logic [nnwr_pkg::IDENT_W-1:0]  r_id4;

    // Running best.
    logic [SMW-1:0]                r_best;
    logic [nnwr_pkg::IDENT_W-1:0]  r_bid;
    logic                          r_found;

    // Result register.
    logic                r_out_valid;
    nnwr_pkg::t_out_item r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_range <= nnwr_pkg::MATCH_RANGE_RST;
            r_row_count   <= nnwr_pkg::ROW_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                nnwr_pkg::CFG_MATCH_RANGE: begin
                    r_match_range <= i_cfg_data[nnwr_pkg::RANGE_W-1:0];
                end
                nnwr_pkg::CFG_ROW_COUNT: begin
                    r_row_count <= i_cfg_data[nnwr_pkg::ROW_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The clearing pass and loads never overlap, so one write port serves both.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx[IDX_W-1:0];
        w_wdata = '0;
        if (i_cmd.clr_wr) begin
            w_we = 1'b1;
        end else if (i_cmd.ld_wr && (32'(i_in_item.slot) < TABLE_SLOTS)) begin
            w_we          = 1'b1;
            w_waddr       = IDX_W'(i_in_item.slot);
            w_wdata.valid = i_in_item.slot_present;
            w_wdata.map   = i_in_item.map_number;
            w_wdata.ident = i_in_item.node_ident;
            w_wdata.x     = i_in_item.pos_x;
            w_wdata.y     = i_in_item.pos_y;
            w_wdata.z     = i_in_item.pos_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_issue) begin
            r_rd <= r_mem[r_idx[IDX_W-1:0]];
        end
    end

    // Scan limit is the row count clipped to the table size.
    always_comb begin
        w_row_ext = CW'(r_row_count);
        w_lim     = (w_row_ext > CW'(TABLE_SLOTS)) ? CW'(TABLE_SLOTS) : w_row_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.q_start) begin
            r_idx <= LIM_W'(1);
        end else if (i_cmd.clr_wr || i_cmd.scan_issue) begin
            r_idx <= r_idx + LIM_W'(1);
        end
    end

    assign w_rsq = nnwr_pkg::RSQ_W'(r_match_range) * nnwr_pkg::RSQ_W'(r_match_range);

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_start) begin
            r_limit <= LIM_W'(w_lim);
            r_qmap  <= i_in_item.map_number;
            r_qx    <= i_in_item.pos_x;
            r_qy    <= i_in_item.pos_y;
            r_qz    <= i_in_item.pos_z;
        end
    end

    always_comb begin
        w_dx = {r_rd.x[CB-1], r_rd.x} - {r_qx[CB-1], r_qx};
        w_dy = {r_rd.y[CB-1], r_rd.y} - {r_qy[CB-1], r_qy};
        w_dz = {r_rd.z[CB-1], r_rd.z} - {r_qz[CB-1], r_qz};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.scan_issue;
            r_v2 <= r_v1 && r_rd.valid && (r_rd.map == r_qmap);
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ax  <= w_dx[DW-1] ? DW'(-w_dx) : DW'(w_dx);
        r_ay  <= w_dy[DW-1] ? DW'(-w_dy) : DW'(w_dy);
        r_az  <= w_dz[DW-1] ? DW'(-w_dz) : DW'(w_dz);
        r_id2 <= r_rd.ident;
        r_sqx <= SQW'(r_ax) * SQW'(r_ax);
        r_sqy <= SQW'(r_ay) * SQW'(r_ay);
        r_sqz <= SQW'(r_az) * SQW'(r_az);
        r_id3 <= r_id2;
        r_sum <= SMW'(r_sqx) + SMW'(r_sqy) + SMW'(r_sqz);
        r_id4 <= r_id3;
    end

    // Strictly smaller wins, so the lowest slot keeps a tie.
    always_ff @(posedge i_clk) begin
        if (i_cmd.q_start) begin
            r_best  <= SMW'(w_rsq);
            r_bid   <= '0;
            r_found <= 1'b0;
        end else if (r_v4 && (r_sum < r_best)) begin
            r_best  <= r_sum;
            r_bid   <= r_id4;
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_item.found     <= r_found;
            r_out_item.best_node <= r_found ? r_bid : '0;
        end
    end

    always_comb begin
        o_stat.clr_last   = (r_idx == LIM_W'(TABLE_SLOTS - 1));
        o_stat.scan_none  = (w_lim <= CW'(1));
        o_stat.scan_last  = ({1'b0, r_idx} + (LIM_W + 1)'(1)) >= {1'b0, r_limit};
        o_stat.pipe_empty = !(r_v1 || r_v2 || r_v3 || r_v4);
        o_stat.out_busy   = r_out_valid && !i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `NNWR_ASSERT_NXT(a_out_load_sets_valid, i_clk, i_rst_n, i_cmd.out_load, r_out_valid)
    `NNWR_ASSERT_IMP(a_load_after_drain, i_clk, i_rst_n, i_cmd.out_load, o_stat.pipe_empty)
    `NNWR_ASSERT_IMP(a_tag_from_issue, i_clk, i_rst_n, r_v4, $past(r_v1, 3))
    `NNWR_ASSERT_IMP(a_scan_in_bounds, i_clk, i_rst_n, i_cmd.scan_issue, r_idx < r_limit)

endmodule

`default_nettype wire

[tb/sv/tb_nearest_node_within_range.sv]
`default_nettype none

// Self-checking bench for the nearest node search.
// A short table of hand-picked items is played first. After it come phases of
// random items, each phase under its own match range and row count. Every
// query result is compared with its typed-in answer or with a behavioural copy
// of the node table that is kept in step with the load items that the block accepts.
module tb_nearest_node_within_range;
    timeunit 1ns;
    timeprecision 1ps;

    import nnwr_pkg::*;

    localparam int TABLE_SLOTS = 256;

    // A load is written at the edge that takes it. Waiting out a full scan
    // before a register write leaves a generous margin.
    localparam int SETTLE_CYCLES = TABLE_SLOTS + 16;

    // The slowest correct run has every item as a full-table query that also
    // waits out the longest sender gap and receiver stall. The limit sits several
    // times above that run.
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int MAX_REPORTS = 10;

    localparam int C_MAX = 524287;
    localparam int C_MIN = -524288;

    localparam t_out_item NO_HIT = '{1'b0, 16'h0000};

    // One row of the directed table. It is either an item for the input
    // channel or a register write that is made once the block has gone quiet.
    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_QUERY_TYPED,
        ROW_QUERY_MODEL,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind                kind;
        logic [CFG_IDX_W-1:0]     cfg_idx;
        logic [CFG_DATA_W-1:0]    cfg_data;
        t_in_item                 item;
        t_out_item                want;
    } t_row;

    // The ways in which the receiver stalls; it switches between them as it runs.
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_ONE_IN_FIVE,
        READY_HALVES
    } t_ready_style;

    function automatic t_row load_row(logic [SLOT_W-1:0] slot, logic present,
                                      logic [IDENT_W-1:0] ident, logic [MAP_W-1:0] map,
                                      int x, int y, int z);
        t_row r;
        r = '0;
        r.kind              = ROW_LOAD;
        r.item.mode         = MODE_LOAD;
        r.item.slot         = slot;
        r.item.slot_present = present;
        r.item.node_ident   = ident;
        r.item.map_number   = map;
        r.item.pos_x        = x[COORD_BITS-1:0];
        r.item.pos_y        = y[COORD_BITS-1:0];
        r.item.pos_z        = z[COORD_BITS-1:0];
        return r;
    endfunction

    // The slot, present and identifier fields of a query are filled with
    // junk on purpose, as the block must ignore them.
    function automatic t_row query_row(t_row_kind kind, logic [MAP_W-1:0] map,
                                       int x, int y, int z, t_out_item want);
        t_row r;
        r = '0;
        r.kind              = kind;
        r.item.mode         = MODE_QUERY;
        r.item.slot         = 8'hA5;
        r.item.slot_present = 1'b1;
        r.item.node_ident   = 16'h5AA5;
        r.item.map_number   = map;
        r.item.pos_x        = x[COORD_BITS-1:0];
        r.item.pos_y        = y[COORD_BITS-1:0];
        r.item.pos_z        = z[COORD_BITS-1:0];
        r.want              = want;
        return r;
    endfunction

    function automatic t_row cfg_row(logic [CFG_IDX_W-1:0] idx, int data);
        t_row r;
        r = '0;
        r.kind     = ROW_CFG;
        r.cfg_idx  = idx;
        r.cfg_data = data[CFG_DATA_W-1:0];
        return r;
    endfunction

    // Directed stimulus. Where the answer is plain from the table contents
    // it is typed in, and otherwise the behavioural table supplies it.
    localparam t_row DIRECTED [0:29] = '{
        // A query on the empty table just after reset.
        query_row(ROW_QUERY_TYPED, 16'h0000, 0, 0, 0, NO_HIT),
        // A node at the top corner of the coordinate space, on the top map.
        load_row(8'd1, 1'b1, 16'hFFFF, 16'hFFFF, C_MAX, C_MAX, C_MAX),
        query_row(ROW_QUERY_TYPED, 16'hFFFF, C_MAX, C_MAX, C_MAX, t_out_item'{1'b1, 16'hFFFF}),
        // The opposite corner is as far away as anything can be.
        query_row(ROW_QUERY_TYPED, 16'hFFFF, C_MIN, C_MIN, C_MIN, NO_HIT),
        // Slot zero may be loaded but is never part of a scan.
        load_row(8'd0, 1'b1, 16'h1234, 16'h0007, 0, 0, 0),
        query_row(ROW_QUERY_TYPED, 16'h0007, 0, 0, 0, NO_HIT),
        // The last slot holds a node whose identifier is zero.
        load_row(8'd255, 1'b1, 16'h0000, 16'h0007, C_MIN, C_MIN, C_MIN),
        query_row(ROW_QUERY_TYPED, 16'h0007, C_MIN, C_MIN, C_MIN, t_out_item'{1'b1, 16'h0000}),
        // Two nodes at the same spot: the lower slot must win the tie.
        load_row(8'd2, 1'b1, 16'hAAAA, 16'h0007, C_MIN + 16, C_MIN + 16, C_MIN + 16),
        load_row(8'd3, 1'b1, 16'h5555, 16'h0007, C_MIN + 16, C_MIN + 16, C_MIN + 16),
        query_row(ROW_QUERY_MODEL, 16'h0007, C_MIN + 16, C_MIN + 16, C_MIN + 16, NO_HIT),
        // Emptying the lower slot hands the win to the other one.
        load_row(8'd2, 1'b0, 16'hAAAA, 16'h0007, C_MIN + 16, C_MIN + 16, C_MIN + 16),
        query_row(ROW_QUERY_MODEL, 16'h0007, C_MIN + 16, C_MIN + 16, C_MIN + 16, NO_HIT),
        // A distance equal to the range is out, and one step closer is in.
        load_row(8'd4, 1'b1, 16'h0F0F, 16'h0009, 960, 0, 0),
        query_row(ROW_QUERY_TYPED, 16'h0009, 0, 0, 0, NO_HIT),
        query_row(ROW_QUERY_TYPED, 16'h0009, 1, 0, 0, t_out_item'{1'b1, 16'h0F0F}),
        // The right spot on the wrong map.
        query_row(ROW_QUERY_TYPED, 16'h0008, 960, 0, 0, NO_HIT),
        // With two rows only slot 1 is scanned.
        cfg_row(CFG_ROW_COUNT, 2),
        query_row(ROW_QUERY_TYPED, 16'hFFFF, C_MAX, C_MAX, C_MAX, t_out_item'{1'b1, 16'hFFFF}),
        query_row(ROW_QUERY_TYPED, 16'h0007, C_MIN, C_MIN, C_MIN, NO_HIT),
        // With one row, and with none, nothing is scanned at all.
        cfg_row(CFG_ROW_COUNT, 1),
        query_row(ROW_QUERY_TYPED, 16'hFFFF, C_MAX, C_MAX, C_MAX, NO_HIT),
        cfg_row(CFG_ROW_COUNT, 0),
        query_row(ROW_QUERY_TYPED, 16'hFFFF, C_MAX, C_MAX, C_MAX, NO_HIT),
        // A row count beyond the table stops at its last slot.
        cfg_row(CFG_ROW_COUNT, 511),
        query_row(ROW_QUERY_TYPED, 16'h0007, C_MIN, C_MIN, C_MIN, t_out_item'{1'b1, 16'h0000}),
        // A zero range matches nothing, not even a node at the query point.
        cfg_row(CFG_MATCH_RANGE, 0),
        query_row(ROW_QUERY_TYPED, 16'hFFFF, C_MAX, C_MAX, C_MAX, NO_HIT),
        // The widest range.
        cfg_row(CFG_MATCH_RANGE, 65535),
        query_row(ROW_QUERY_MODEL, 16'h0009, -64000, -64000, -64000, NO_HIT)
    };

    // Random phases: match range (negative picks one at random), row count
    // and number of items. Most phases scan few rows so that the run stays
    // short, and only two scan the whole table.
    localparam int N_PHASES = 9;
    localparam int PHASE_RADIUS [N_PHASES] = '{960, 65535, 0, -1, 300, 200, -1, 1000, 65535};
    localparam int PHASE_ROWS   [N_PHASES] = '{256, 40, 24, 64, 1, 16, 511, 100, 8};
    localparam int PHASE_ITEMS  [N_PHASES] = '{160, 180, 80, 220, 60, 220, 120, 200, 160};

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_ready;
    t_in_item               i_in_item   = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_out_item              o_out_item;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    nearest_node_within_range #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Behavioural copy of the node table and of the two registers.
    logic                          node_valid [TABLE_SLOTS];
    logic [MAP_W-1:0]              node_map   [TABLE_SLOTS];
    logic [IDENT_W-1:0]            node_ident [TABLE_SLOTS];
    logic signed [COORD_BITS-1:0]  node_x     [TABLE_SLOTS];
    logic signed [COORD_BITS-1:0]  node_y     [TABLE_SLOTS];
    logic signed [COORD_BITS-1:0]  node_z     [TABLE_SLOTS];
    logic [RANGE_W-1:0]            cur_radius = MATCH_RANGE_RST;
    logic [ROW_W-1:0]              cur_rows   = ROW_COUNT_RST;

    // Query answers in the order that the block must give them.
    t_out_item expected_nearest [$];

    int burst_left      = 0;
    int loads_sent      = 0;
    int queries_sent    = 0;
    int results_checked = 0;
    int reg_writes      = 0;
    int mismatch_count  = 0;
    int cycle_count     = 0;
    int ready_tick      = 0;
    t_ready_style ready_style = READY_ALWAYS;

    // Nearest node on the query's map whose squared distance is strictly
    // below the squared range. A later slot replaces the best only when it is
    // strictly closer, so the lowest slot wins a tie. Squares of 21-bit
    // differences fit easily in 64 bits.
    function automatic t_out_item nearest_in_range(input t_in_item q);
        longint    best;
        longint    dx;
        longint    dy;
        longint    dz;
        longint    sq_dist;
        int        lim;
        t_out_item r;
        best = longint'(cur_radius) * longint'(cur_radius);
        r    = NO_HIT;
        lim  = (int'(cur_rows) > TABLE_SLOTS) ? TABLE_SLOTS : int'(cur_rows);
        for (int i = 1; i < lim; i++) begin
            if (node_valid[i] && node_map[i] == q.map_number) begin
                dx      = longint'(node_x[i]) - longint'(q.pos_x);
                dy      = longint'(node_y[i]) - longint'(q.pos_y);
                dz      = longint'(node_z[i]) - longint'(q.pos_z);
                sq_dist = dx * dx + dy * dy + dz * dz;
                if (sq_dist < best) begin
                    best        = sq_dist;
                    r.found     = 1'b1;
                    r.best_node = node_ident[i];
                end
            end
        end
        return r;
    endfunction

    // A point within span of the centre on each axis.
    function automatic logic signed [COORD_BITS-1:0] near(int centre, int span);
        return COORD_BITS'(centre + int'($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic note_failure(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] MISMATCH: %s", $realtime, what);
        end
    endtask

    // Presents one item and returns at the edge that takes it. Valid drops
    // only for a gap between bursts, so back-to-back items keep it high.
    // The slot of a load is always inside the table, since the field is
    // eight bits wide.
    task automatic send_item(input t_in_item it, input logic typed, input t_out_item want);
        int        gap;
        t_out_item answer;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        if (it.mode == MODE_QUERY) begin
            answer = typed ? want : nearest_in_range(it);
            expected_nearest = {expected_nearest, answer};
            queries_sent++;
        end else begin
            node_valid[it.slot] = it.slot_present;
            node_map[it.slot]   = it.map_number;
            node_ident[it.slot] = it.node_ident;
            node_x[it.slot]     = it.pos_x;
            node_y[it.slot]     = it.pos_y;
            node_z[it.slot]     = it.pos_z;
            loads_sent++;
        end
    endtask

    // Lets every pending answer come out, then allows any late load to land.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (expected_nearest.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write. The enable drops after the edge that takes the write, and the
    // task returns only after an edge with the enable low, so that a following write raises it afresh.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MATCH_RANGE) begin
            cur_radius = data[RANGE_W-1:0];
        end else if (idx == CFG_ROW_COUNT) begin
            cur_rows = data[ROW_W-1:0];
        end
        reg_writes++;
        @(posedge i_clk);
    endtask

    // The receiver switches between always ready, a coin toss, one stall
    // in five, and runs on and off taken from bit 2 of the tick count.
    always @(posedge i_clk) begin
        ready_tick++;
        if (ready_tick % 64 == 0) begin
            ready_style = t_ready_style'($urandom_range(0, 3));
        end
        case (ready_style)
            READY_ALWAYS: begin
                i_out_ready <= 1'b1;
            end
            READY_COIN: begin
                i_out_ready <= 1'($urandom_range(0, 1));
            end
            READY_ONE_IN_FIVE: begin
                i_out_ready <= (ready_tick % 5) != 0;
            end
            default: begin
                i_out_ready <= ready_tick[2];
            end
        endcase
    end

    // Each result taken is checked against the oldest pending answer.
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_checked++;
            if (expected_nearest.size() == 0) begin
                note_failure($sformatf("result %0d (found=%0b node=%h) with no query pending",
                                       results_checked, o_out_item.found,
                                       o_out_item.best_node));
            end else begin
                want = expected_nearest.pop_front();
                if (o_out_item.found !== want.found) begin
                    note_failure($sformatf("result %0d found: expected %0b, got %0b",
                                           results_checked, want.found, o_out_item.found));
                end
                if (o_out_item.best_node !== want.best_node) begin
                    note_failure($sformatf("result %0d best_node: expected %h, got %h",
                                           results_checked, want.best_node,
                                           o_out_item.best_node));
                end
            end
        end
    end

    // Watchdog on a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d answers pending.",
                     cycle_count, expected_nearest.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_row                          row;
        t_in_item                      it;
        int                            radius;
        int                            span;
        int                            rows_in_use;
        int                            pick;
        int                            k;
        logic [MAP_W-1:0]              pool_map [4];
        int                            pool_x   [4];
        int                            pool_y   [4];
        int                            pool_z   [4];
        logic signed [COORD_BITS-1:0]  last_x;
        logic signed [COORD_BITS-1:0]  last_y;
        logic signed [COORD_BITS-1:0]  last_z;

        for (int i = 0; i < TABLE_SLOTS; i++) begin
            node_valid[i] = 1'b0;
        end
        last_x = '0;
        last_y = '0;
        last_z = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The block sweeps its table clear after reset and
        // takes no item meanwhile, which the handshake absorbs.
        foreach (DIRECTED[r]) begin
            row = DIRECTED[r];
            if (row.kind == ROW_CFG) begin
                wait_idle();
                cfg_write(row.cfg_idx, row.cfg_data);
            end else begin
                send_item(row.item, row.kind == ROW_QUERY_TYPED, row.want);
            end
        end

        // Random part. Each phase works on four maps, each with a cluster
        // centre, so that loads and queries meet. The third map is always
        // all zeros or all ones. A small share of items is pure noise.
        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            radius = (PHASE_RADIUS[p] < 0) ? $urandom_range(1, 4000) : PHASE_RADIUS[p];
            cfg_write(CFG_MATCH_RANGE, CFG_DATA_W'(radius));
            cfg_write(CFG_ROW_COUNT, CFG_DATA_W'(PHASE_ROWS[p]));
            rows_in_use = (PHASE_ROWS[p] > TABLE_SLOTS) ? TABLE_SLOTS : PHASE_ROWS[p];
            span = (radius > 1) ? radius / 2 : 32;
            for (int m = 0; m < 4; m++) begin
                pool_map[m] = MAP_W'($urandom);
                pool_x[m]   = int'($urandom_range(0, 900000)) - 450000;
                pool_y[m]   = int'($urandom_range(0, 900000)) - 450000;
                pool_z[m]   = int'($urandom_range(0, 900000)) - 450000;
            end
            pool_map[2] = (p % 2 == 1) ? 16'hFFFF : 16'h0000;

            for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
                pick = $urandom_range(0, 99);
                k    = $urandom_range(0, 3);
                // Start from noise in every field, then shape it.
                it              = '0;
                it.slot         = SLOT_W'($urandom);
                it.slot_present = 1'($urandom);
                it.node_ident   = IDENT_W'($urandom);
                it.map_number   = MAP_W'($urandom);
                it.pos_x        = COORD_BITS'($urandom);
                it.pos_y        = COORD_BITS'($urandom);
                it.pos_z        = COORD_BITS'($urandom);
                if (pick < 50) begin
                    // Load into a scanned row, now and then into one outside
                    // the rows in use. Some loads repeat the last spot to
                    // set up ties, and a few empty their slot.
                    it.mode = MODE_LOAD;
                    if (rows_in_use > 1 && $urandom_range(0, 9) != 0) begin
                        it.slot = SLOT_W'($urandom_range(1, rows_in_use - 1));
                    end
                    it.slot_present = ($urandom_range(0, 9) != 0);
                    it.map_number   = pool_map[k];
                    if ($urandom_range(0, 9) == 0) begin
                        it.pos_x = last_x;
                        it.pos_y = last_y;
                        it.pos_z = last_z;
                    end else begin
                        it.pos_x = near(pool_x[k], span);
                        it.pos_y = near(pool_y[k], span);
                        it.pos_z = near(pool_z[k], span);
                    end
                    last_x = it.pos_x;
                    last_y = it.pos_y;
                    last_z = it.pos_z;
                end else if (pick < 55) begin
                    it.mode = MODE_LOAD;
                end else if (pick < 95) begin
                    // Query near a cluster, or right on the latest node.
                    it.mode = MODE_QUERY;
                    if ($urandom_range(0, 9) != 0) begin
                        it.map_number = pool_map[k];
                    end
                    if ($urandom_range(0, 4) == 0) begin
                        it.pos_x = last_x;
                        it.pos_y = last_y;
                        it.pos_z = last_z;
                    end else begin
                        it.pos_x = near(pool_x[k], span);
                        it.pos_y = near(pool_y[k], span);
                        it.pos_z = near(pool_z[k], span);
                    end
                end else begin
                    it.mode = MODE_QUERY;
                end
                send_item(it, 1'b0, NO_HIT);
            end
        end

        wait_idle();
        if (expected_nearest.size() != 0) begin
            note_failure($sformatf("%0d answers never arrived", expected_nearest.size()));
        end

        $display("Covered %0d loads and %0d queries over %0d register writes in %0d cycles.",
                 loads_sent, queries_sent, reg_writes, cycle_count);
        $display("Checked %0d results, %0d field mismatches.", results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
